// File: hdl/gclr_pkg.sv
// Package for the covariant Laplacian row unit: lattice geometry, widths and op codes.
// No dependencies.
`default_nettype none
package gclr_pkg;
    localparam int LatticeSide  = 4;
    localparam int FractionBits = 16;
    localparam int SiteCount    = LatticeSide * LatticeSide * LatticeSide;
    localparam int VecDepth     = SiteCount * 3;
    localparam int SlotWords    = 72;
    localparam int LinkDepth    = ((SiteCount + 1) / 2) * SlotWords;
    localparam int LinkAw       = $clog2(LinkDepth);
    localparam int VecAw        = $clog2(VecDepth);
    localparam int CoordW       = $clog2(LatticeSide);
    localparam int SiteW        = $clog2(SiteCount);
    // row / 3 by reciprocal multiply, exact for any row below 2**VecAw
    localparam int DivShift     = VecAw + 2;
    localparam int DivMul       = (2 ** DivShift + 2) / 3;
    localparam int QuotW        = 2 * VecAw + 2;

    typedef enum logic [1:0] {
        OP_LOAD_LINK = 2'd0,
        OP_LOAD_VEC  = 2'd1,
        OP_COMPUTE   = 2'd2,
        OP_NONE      = 2'd3
    } t_op;
endpackage
`default_nettype wire

// File: hdl/gclr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gclr_ram #(
    parameter int Width = 64,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/gclr_addr.sv
// Address sequencer: steps through the diagonal term and 18 neighbour terms of one row.
// Depends on gclr_pkg.
`default_nettype none
module gclr_addr (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [gclr_pkg::VecAw-1:0] i_row,
    output logic                           o_rd_valid,
    output logic                           o_rd_diag,
    output logic                           o_rd_last,
    output logic                           o_even,
    output logic [gclr_pkg::VecAw-1:0]     o_vaddr,
    output logic [gclr_pkg::LinkAw-1:0]    o_laddr
);
    import gclr_pkg::*;

    logic              r_busy, n_busy;
    logic [4:0]        r_step, n_step;       // 0 diagonal, 1..18 neighbour terms
    logic [2:0]        r_d, n_d;             // neighbour direction
    logic [1:0]        r_b, n_b;             // colour of the neighbour vector word
    logic [SiteW-1:0]  r_site;
    logic [1:0]        r_c;
    logic [QuotW-1:0]  q_prod;
    logic [SiteW-1:0]  row_site;
    logic [1:0]        row_c;
    logic [CoordW-1:0] j, k, l, nj, nk, nl;
    logic [2:0]        mu;
    logic [SiteW-1:0]  nsite;
    logic [SiteW-1:0]  slot_site;
    logic [SiteW-2:0]  slot;
    logic [3:0]        entry;

    assign q_prod   = QuotW'(i_row) * QuotW'(DivMul);
    assign row_site = SiteW'(q_prod >> DivShift);
    assign row_c    = 2'(i_row - VecAw'(row_site * 3));

    assign j = r_site[CoordW-1:0];
    assign k = r_site[2*CoordW-1:CoordW];
    assign l = r_site[3*CoordW-1:2*CoordW];
    assign o_even = ~(j[0] ^ k[0] ^ l[0]);

    always_comb begin
        nj = j; nk = k; nl = l;
        mu = 3'd0;
        unique case (r_d)
            3'd0: begin nj = (j == '0) ? CoordW'(LatticeSide-1) : j - 1'b1; mu = 3'd6; end
            3'd1: begin nj = (j == CoordW'(LatticeSide-1)) ? '0 : j + 1'b1; mu = 3'd7; end
            3'd2: begin nk = (k == '0) ? CoordW'(LatticeSide-1) : k - 1'b1; mu = 3'd4; end
            3'd3: begin nk = (k == CoordW'(LatticeSide-1)) ? '0 : k + 1'b1; mu = 3'd5; end
            3'd4: begin nl = (l == '0) ? CoordW'(LatticeSide-1) : l - 1'b1; mu = 3'd2; end
            default: begin nl = (l == CoordW'(LatticeSide-1)) ? '0 : l + 1'b1; mu = 3'd3; end
        endcase
        nsite = {nl, nk, nj};
        // odd sites swap mu within each pair and use their own slot
        if (!o_even) mu = mu ^ 3'd1;
        slot_site = o_even ? nsite : r_site;
        slot = slot_site[SiteW-1:1];
        entry = o_even ? 4'(r_c + 3 * r_b) : 4'(3 * r_c + r_b);
        o_laddr = LinkAw'(slot * SlotWords + mu * 9 + entry);
        o_vaddr = (r_step == 5'd0) ? VecAw'(r_site * 3 + r_c) : VecAw'(nsite * 3 + r_b);
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_d    = r_d;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_d    = '0;
            n_b    = '0;
        end else if (r_busy) begin
            if (r_step == 5'd18) n_busy = 1'b0;
            n_step = r_step + 1'b1;
            if (r_step != 5'd0) begin
                if (r_b == 2'd2) begin
                    n_b = '0;
                    n_d = r_d + 1'b1;
                end else begin
                    n_b = r_b + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_d    <= '0;
            r_b    <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_d    <= n_d;
            r_b    <= n_b;
        end
        if (i_start) begin
            r_site <= row_site;
            r_c    <= row_c;
        end
    end

    assign o_rd_valid = r_busy;
    assign o_rd_diag  = (r_step == 5'd0);
    assign o_rd_last  = (r_step == 5'd18);
endmodule
`default_nettype wire

// File: hdl/gclr_mac.sv
// Accumulator: one complex link*vector product per cycle, multipliers registered, saturating.
// Depends on gclr_pkg.
`default_nettype none
module gclr_mac (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_diag,
    input  wire logic        i_last,
    input  wire logic        i_even,
    input  wire logic [63:0] i_vec,
    input  wire logic [63:0] i_link,
    output logic             o_done,
    output logic [31:0]      o_re,
    output logic [31:0]      o_im,
    output logic             o_sat
);
    import gclr_pkg::*;

    logic signed [31:0] xr, xi, ur, ui;
    logic signed [63:0] r_prr, r_pii, r_pir, r_pri;
    logic signed [35:0] r_xr6, r_xi6;
    logic               r_v1, r_diag1, r_last1, r_even1;
    logic               r_v2;
    logic signed [67:0] r_acc_re, r_acc_im, n_acc_re, n_acc_im;
    logic signed [67:0] srr, sii, sir, sri, dre, dim;

    assign xr = i_vec[31:0];
    assign xi = i_vec[63:32];
    assign ur = i_link[31:0];
    assign ui = i_link[63:32];

    always_ff @(posedge i_clk) begin
        r_prr <= xr * ur;
        r_pii <= xi * ui;
        r_pir <= xi * ur;
        r_pri <= xr * ui;
        r_xr6 <= 36'(xr) * 36'sd6;
        r_xi6 <= 36'(xi) * 36'sd6;
        r_diag1 <= i_diag;
        r_last1 <= i_last;
        r_even1 <= i_even;
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
    end

    always_comb begin
        srr = 68'(r_prr >>> FractionBits);
        sii = 68'(r_pii >>> FractionBits);
        sir = 68'(r_pir >>> FractionBits);
        sri = 68'(r_pri >>> FractionBits);
        if (r_even1) begin
            dre = srr + sii;
            dim = sir - sri;
        end else begin
            dre = srr - sii;
            dim = sri + sir;
        end
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        if (r_v1) begin
            if (r_diag1) begin
                n_acc_re = 68'(r_xr6);
                n_acc_im = 68'(r_xi6);
            end else begin
                n_acc_re = r_acc_re - dre;
                n_acc_im = r_acc_im - dim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1 && r_last1;
        end
    end

    logic re_hi, re_lo, im_hi, im_lo;
    assign re_hi = r_acc_re > 68'sd2147483647;
    assign re_lo = r_acc_re < -68'sd2147483648;
    assign im_hi = r_acc_im > 68'sd2147483647;
    assign im_lo = r_acc_im < -68'sd2147483648;
    assign o_re  = re_hi ? 32'h7fffffff : re_lo ? 32'h80000000 : r_acc_re[31:0];
    assign o_im  = im_hi ? 32'h7fffffff : im_lo ? 32'h80000000 : r_acc_im[31:0];
    assign o_sat = re_hi | re_lo | im_hi | im_lo;
    assign o_done = r_v2;
endmodule
`default_nettype wire

// File: hdl/gauge_covariant_laplacian_row.sv
// Top level of the covariant Laplacian row unit: loads, memories, sequencer, accumulator, output.
// Depends on gclr_pkg, gclr_ram, gclr_addr, gclr_mac.
// Loads give no word out. A compute reads one memory pair per cycle for the diagonal
// plus 18 neighbour terms, and gives one result word.
// One compute at a time: the next word is taken in the cycle after the row word leaves, so
// output stalls hold off the next word.
// Synchronous active-low reset clears control only; memories hold garbage until written.
`default_nettype none
module gauge_covariant_laplacian_row (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [79:0]  s_axis_tdata,   // index[11:0], value_re[43:12], value_im[75:44], 0
    input  wire logic [1:0]   s_axis_tuser,   // op
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata,   // row_number[7:0], result_re[39:8], result_im[71:40]
    output logic              m_axis_tuser    // saturated
);
    import gclr_pkg::*;

    logic        acc;
    logic [11:0] idx;
    logic [63:0] wword;
    logic        we_link, we_vec, start;
    logic        rd_valid, rd_diag, rd_last, even;
    logic [VecAw-1:0]  vaddr, vw_addr;
    logic [LinkAw-1:0] laddr;
    logic [63:0] vdata, ldata;
    logic        r_rv, r_rdiag, r_rlast, r_reven;
    logic        done, sat;
    logic [31:0] res_re, res_im;
    logic        r_pend;   // compute in flight until its word is loaded out
    logic [7:0]  r_row;
    logic        r_ovalid;
    logic [71:0] r_odata;
    logic        r_osat;

    assign idx   = s_axis_tdata[11:0];
    assign wword = {s_axis_tdata[75:44], s_axis_tdata[43:12]};
    assign s_axis_tready = !r_pend;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign we_link = acc && (t_op'(s_axis_tuser) == OP_LOAD_LINK) && (idx < 12'(LinkDepth));
    assign we_vec  = acc && (t_op'(s_axis_tuser) == OP_LOAD_VEC) && (idx < 12'(VecDepth));
    assign start   = acc && (t_op'(s_axis_tuser) == OP_COMPUTE) && (idx < 12'(VecDepth));
    assign vw_addr = VecAw'(idx);

    gclr_ram #(.Width(64), .Depth(LinkDepth)) u_link (
        .i_clk(i_clk), .i_we(we_link), .i_waddr(LinkAw'(idx)), .i_wdata(wword),
        .i_raddr(laddr), .o_rdata(ldata));
    gclr_ram #(.Width(64), .Depth(VecDepth)) u_vec (
        .i_clk(i_clk), .i_we(we_vec), .i_waddr(vw_addr), .i_wdata(wword),
        .i_raddr(vaddr), .o_rdata(vdata));

    gclr_addr u_addr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_row(vw_addr),
        .o_rd_valid(rd_valid), .o_rd_diag(rd_diag), .o_rd_last(rd_last),
        .o_even(even), .o_vaddr(vaddr), .o_laddr(laddr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rv <= 1'b0;
        else          r_rv <= rd_valid;
        r_rdiag <= rd_diag;
        r_rlast <= rd_last;
        r_reven <= even;
    end

    gclr_mac u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_rv), .i_diag(r_rdiag),
        .i_last(r_rlast), .i_even(r_reven), .i_vec(vdata), .i_link(ldata),
        .o_done(done), .o_re(res_re), .o_im(res_im), .o_sat(sat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (start) r_pend <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_pend <= 1'b0;
            if (done) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
        if (start) r_row <= idx[7:0];
        if (done) begin
            r_odata <= {res_im, res_re, r_row};
            r_osat  <= sat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;
endmodule
`default_nettype wire
